// ===== design/copf_pkg.sv =====
// ----------------------------------------------------------------------------
// copf_pkg
// Shared types for the circle overlap pair finder: the input and result
// transactions, the stored circle record, the compare unit status and the
// sequencer state codes.
// ----------------------------------------------------------------------------
package copf_pkg;

  // One circle as it arrives on the input channel
  typedef struct packed {
    logic               frame_start;
    logic        [15:0] entity_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] radius;
  } circle_in_t;

  // One pair result on the output channel
  typedef struct packed {
    logic [15:0] new_id;
    logic [15:0] earlier_id;
    logic        overflow;
    logic        last_of_run;
  } pair_out_t;

  // Stored circle record, 64 bits
  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] r;
  } circle_t;

  // Status from the compare unit back to the sequencer
  typedef struct packed {
    logic        busy;    // a compare is still in flight
    logic        hit;     // final stage holds an overlapping pair
    logic [15:0] hit_id;  // id of the stored circle of that pair
  } cmp_stat_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } seq_state_t;

endpackage

// ===== design/copf_cmp.sv =====
// ----------------------------------------------------------------------------
// copf_cmp
// Pipelined overlap test shared by every stored circle of a scan. Takes one
// stored circle per enabled cycle; three stages: differences, squares, compare.
// ----------------------------------------------------------------------------
module copf_cmp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  copf_pkg::circle_t  stored,
  input  copf_pkg::circle_t  cur,
  output copf_pkg::cmp_stat_t stat
);
  import copf_pkg::*;

  // stage 1: differences and radius sum
  logic               v1_r;
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic        [16:0] rs_r;
  logic        [15:0] id1_r;

  // stage 2: squares
  logic               v2_r;
  logic        [32:0] dx2_r;
  logic        [32:0] dy2_r;
  logic        [33:0] rs2_r;
  logic        [15:0] id2_r;

  // stage 3: compare result
  logic               hit_r;
  logic        [15:0] id3_r;

  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic        [33:0] d2;

  assign dx_sq = 34'(dx_r) * 34'(dx_r);
  assign dy_sq = 34'(dy_r) * 34'(dy_r);
  assign d2    = {1'b0, dx2_r} + {1'b0, dy2_r};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      hit_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_v;
      v2_r  <= v1_r;
      hit_r <= v2_r && (d2 < rs2_r);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= 17'(cur.x) - 17'(stored.x);
      dy_r  <= 17'(cur.y) - 17'(stored.y);
      rs_r  <= {1'b0, cur.r} + {1'b0, stored.r};
      id1_r <= stored.id;
      dx2_r <= dx_sq[32:0];
      dy2_r <= dy_sq[32:0];
      rs2_r <= 34'(rs_r) * 34'(rs_r);
      id2_r <= id1_r;
      id3_r <= id2_r;
    end
  end

  assign stat.busy   = in_v || v1_r || v2_r;
  assign stat.hit    = hit_r;
  assign stat.hit_id = id3_r;

  // a hit only follows a valid compare in the squares stage
  a_hit_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    en && !v2_r |=> !hit_r)
    else $error("copf_cmp: hit without a compare in flight");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(hit_r) && $stable(id3_r))
    else $error("copf_cmp: pipeline moved while stalled");

  a_v1_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_v |=> v1_r)
    else $error("copf_cmp: compare dropped at first stage");

endmodule

// ===== design/circle_overlap_pair_finder.sv =====
// Stalls: after an acceptance the input stalls while the stored circles of the
// frame (at most MAX_CIRCLES - 1 tested) are scanned, no scan runs with a full
// store, and a new circle is taken only once the last one has been finished.
// Throughput: one stored circle per cycle, set by the single memory read port
// feeding the shared compare pipeline; output stalls hold the scan. Reset empties
// the store count and clears all valid state; memory contents are left as they are.
// ----------------------------------------------------------------------------
// circle_overlap_pair_finder
// Tests each new circle against the circles stored earlier in its frame, reports
// every overlapping pair, marks the last of the item, and flags overflow when full.
// ----------------------------------------------------------------------------
module circle_overlap_pair_finder #(
  parameter int MAX_CIRCLES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  copf_pkg::circle_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output copf_pkg::pair_out_t    out_data
);
  import copf_pkg::*;

  localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  seq_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  circle_t     cur_r;
  logic        ovf_r;

  circle_t     mem [MAX_CIRCLES];
  circle_t     rd_data_r;
  logic        rd_v_r;

  pair_out_t   pend_r;
  logic        pend_v_r;
  pair_out_t   out_r;
  logic        out_v_r;

  cmp_stat_t   stat;

  logic        accept;
  logic        full_eff;
  logic [CW-1:0] count_eff;
  logic        scan;
  logic        out_free;
  logic        adv;
  logic        rd_en;
  logic        scan_done;
  logic        fin_go;
  logic        load_scan;
  logic        load_fin;

  // handshake and control
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign count_eff = in_data.frame_start ? '0 : count_r;
  assign full_eff  = (count_eff == CW'(MAX_CIRCLES));
  assign scan      = (state_r == ST_SCAN);
  assign out_free  = !out_v_r || !out_stall;
  assign adv       = !(stat.hit && pend_v_r && !out_free);
  assign rd_en     = scan && adv && (idx_r < count_r);
  assign scan_done = scan && (idx_r == count_r) && !rd_v_r && !stat.busy && !stat.hit;
  assign fin_go    = (state_r == ST_FINISH) && (!pend_v_r || out_free);
  assign load_scan = scan && adv && stat.hit && pend_v_r;
  assign load_fin  = fin_go && pend_v_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt = count_eff;
          idx_nxt   = '0;
          state_nxt = full_eff ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          if (!ovf_r) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // latch the new circle
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r.id <= in_data.entity_id;
      cur_r.x  <= in_data.pos_x;
      cur_r.y  <= in_data.pos_y;
      cur_r.r  <= in_data.radius;
      ovf_r    <= full_eff;
    end
  end

  // circle store: written at the end of an item, read once per scan step
  always_ff @(posedge clk) begin
    if (fin_go && !ovf_r) begin
      mem[count_r[AW-1:0]] <= cur_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (adv) begin
      rd_v_r <= rd_en;
    end
  end

  // shared compare pipeline
  copf_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_v   (rd_v_r),
    .stored (rd_data_r),
    .cur    (cur_r),
    .stat   (stat)
  );

  // one result held back so the last of the item can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (accept && full_eff) begin
      pend_v_r <= 1'b1;
    end else if (scan && adv && stat.hit) begin
      pend_v_r <= 1'b1;
    end else if (fin_go) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && full_eff) begin
      pend_r.new_id      <= in_data.entity_id;
      pend_r.earlier_id  <= '0;
      pend_r.overflow    <= 1'b1;
      pend_r.last_of_run <= 1'b0;
    end else if (scan && adv && stat.hit) begin
      pend_r.new_id      <= cur_r.id;
      pend_r.earlier_id  <= stat.hit_id;
      pend_r.overflow    <= 1'b0;
      pend_r.last_of_run <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_scan || load_fin) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_scan) begin
      out_r <= pend_r;
    end else if (load_fin) begin
      out_r             <= pend_r;
      out_r.last_of_run <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("pair finder: ready straight after accepting a circle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CIRCLES))
    else $error("pair finder: store count beyond capacity");

  a_overflow_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.overflow |-> out_r.last_of_run && (out_r.earlier_id == '0))
    else $error("pair finder: malformed overflow result");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    scan && !adv |=> $stable(idx_r) && $stable(pend_r))
    else $error("pair finder: scan moved while the output was blocked");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle overlap pair finder. Each accepted circle
// goes through a bench-side pair predictor, and every result transaction is
// compared field by field with the oldest pending pair. A short directed table
// covers the extremes: touching circles, zero radii, frame starts and the
// empty store after reset. Random frames follow, two of them filled beyond
// capacity. Input gaps and output stalls vary from phase to phase, and one
// long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import copf_pkg::*;

  localparam int MAX_CIRCLES    = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 64;

  // How a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_PAIRS,
    ROW_ONE_PAIR
  } row_kind_t;

  typedef struct {
    circle_in_t circle;
    row_kind_t  kind;
    pair_out_t  pair;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  circle_in_t in_data;
  logic       out_valid;
  logic       out_stall;
  pair_out_t  out_data;

  // Bench-side copy of the frame store
  circle_in_t  frame_circles [MAX_CIRCLES];
  int unsigned frame_count;
  pair_out_t   new_pairs [$];
  pair_out_t   pending_pairs [$];

  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          hold_req;
  stim_row_t   directed_rows [15];

  circle_overlap_pair_finder #(
    .MAX_CIRCLES (MAX_CIRCLES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic circle_in_t make_circle(bit fs, int id, int x, int y, int r);
    circle_in_t c;
    c.frame_start = fs;
    c.entity_id   = 16'(id);
    c.pos_x       = 16'(x);
    c.pos_y       = 16'(y);
    c.radius      = 16'(r);
    return c;
  endfunction

  // The only pair of an item: never an overflow, always last
  function automatic pair_out_t sole_pair(int new_id, int earlier_id);
    pair_out_t p;
    p.new_id      = 16'(new_id);
    p.earlier_id  = 16'(earlier_id);
    p.overflow    = 1'b0;
    p.last_of_run = 1'b1;
    return p;
  endfunction

  // Exact integer test: squared distance strictly below squared radius sum
  function automatic bit circles_overlap(circle_in_t a, circle_in_t b);
    longint dx;
    longint dy;
    longint rsum;
    dx   = longint'($signed(a.pos_x)) - longint'($signed(b.pos_x));
    dy   = longint'($signed(a.pos_y)) - longint'($signed(b.pos_y));
    rsum = longint'(a.radius) + longint'(b.radius);
    return (dx * dx + dy * dy) < (rsum * rsum);
  endfunction

  // Pairs caused by one circle; updates the frame store
  function automatic void predict_pairs(circle_in_t c);
    pair_out_t p;
    new_pairs.delete();
    if (c.frame_start) begin
      frame_count = 0;
    end
    p.new_id = c.entity_id;
    if (frame_count >= MAX_CIRCLES) begin
      p.earlier_id  = '0;
      p.overflow    = 1'b1;
      p.last_of_run = 1'b1;
      new_pairs = {new_pairs, p};
      return;
    end
    p.overflow    = 1'b0;
    p.last_of_run = 1'b0;
    for (int i = 0; i < frame_count; i++) begin
      if (circles_overlap(c, frame_circles[i])) begin
        p.earlier_id = frame_circles[i].entity_id;
        new_pairs = {new_pairs, p};
      end
    end
    if (new_pairs.size() > 0) begin
      new_pairs[new_pairs.size() - 1].last_of_run = 1'b1;
    end
    frame_circles[frame_count] = c;
    frame_count++;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Offer one circle, wait for acceptance, then queue what it should cause
  task automatic offer_circle(input circle_in_t c, input row_kind_t kind,
                              input pair_out_t typed_pair);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pairs(c);
    case (kind)
      ROW_NO_PAIRS: begin
      end
      ROW_ONE_PAIR: begin
        pending_pairs = {pending_pairs, typed_pair};
      end
      default: begin
        pending_pairs = {pending_pairs, new_pairs};
      end
    endcase
  endtask

  // Pause the sender until every pending pair has come out
  task automatic drain_pairs();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
  endtask

  // Random frames: mostly clustered circles so that pairs are common
  task automatic run_frames(input int target_items, input bit with_full_frame);
    int done_items;
    int len;
    int cx;
    int cy;
    int sel;
    circle_in_t c;
    done_items = 0;
    while (done_items < target_items) begin
      len = (with_full_frame && done_items == 0) ? MAX_CIRCLES + 2 : $urandom_range(1, 12);
      cx  = int'($urandom_range(0, 65535)) - 32768;
      cy  = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < len; k++) begin
        sel = $urandom_range(0, 99);
        c.frame_start = (k == 0) || (len <= 12 && $urandom_range(0, 99) < 3);
        c.entity_id   = 16'($urandom);
        if (sel < 75) begin
          c.pos_x  = 16'(cx + int'($urandom_range(0, 1023)) - 512);
          c.pos_y  = 16'(cy + int'($urandom_range(0, 1023)) - 512);
          c.radius = 16'($urandom_range(0, 320));
        end else if (sel < 90) begin
          c.pos_x  = 16'($urandom);
          c.pos_y  = 16'($urandom);
          c.radius = 16'($urandom);
        end else begin
          c.pos_x  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          c.pos_y  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          c.radius = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        offer_circle(c, ROW_PREDICT, '0);
      end
      done_items += len;
    end
  endtask

  // Result side: random stalls, with one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each result transaction with the oldest pending pair
  always @(posedge clk) begin
    pair_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = pending_pairs.pop_front();
        check_field("new_id", want.new_id, out_data.new_id);
        check_field("earlier_id", want.earlier_id, out_data.earlier_id);
        check_field("overflow", 16'(want.overflow), 16'(out_data.overflow));
        check_field("last_of_run", 16'(want.last_of_run), 16'(out_data.last_of_run));
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    frame_count  = 0;

    // Directed rows: extremes, touching circles, zero radii, frame starts
    directed_rows = '{
      // store empty after reset
      '{make_circle(0, 'hFFFF, -32768, -32768, 'hFFFF), ROW_NO_PAIRS, '0},
      // opposite corners, largest radii still overlap
      '{make_circle(0, 'h0000, 32767, 32767, 'hFFFF), ROW_ONE_PAIR, sole_pair('h0000, 'hFFFF)},
      '{make_circle(1, 'h0001, 0, 0, 0), ROW_NO_PAIRS, '0},
      // coincident centres, both radii zero
      '{make_circle(0, 'h0002, 0, 0, 0), ROW_NO_PAIRS, '0},
      '{make_circle(1, 'h0003, 0, 0, 16), ROW_NO_PAIRS, '0},
      // touching, not overlapping
      '{make_circle(0, 'h0004, 32, 0, 16), ROW_NO_PAIRS, '0},
      '{make_circle(0, 'h0005, 16, 1, 16), ROW_PREDICT, '0},
      '{make_circle(0, 'h0006, 16, -32768, 1), ROW_PREDICT, '0},
      '{make_circle(0, 'hAAAA, -16, 0, 'h5555), ROW_PREDICT, '0},
      '{make_circle(1, 'h5555, -32768, 32767, 0), ROW_NO_PAIRS, '0},
      '{make_circle(0, 'h8000, 32767, -32768, 'h8000), ROW_PREDICT, '0},
      // touches the first circle at full span, overlaps the second
      '{make_circle(0, 'h7FFF, -32768, -32768, 'hFFFF), ROW_ONE_PAIR, sole_pair('h7FFF, 'h8000)},
      '{make_circle(0, 'h1234, 0, 0, 1), ROW_PREDICT, '0},
      '{make_circle(1, 'h0010, 100, 100, 50), ROW_NO_PAIRS, '0},
      '{make_circle(0, 'h0011, 100, 100, 0), ROW_ONE_PAIR, sole_pair('h0011, 'h0010)}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_circle(directed_rows[i].circle, directed_rows[i].kind, directed_rows[i].pair);
    end
    drain_pairs();

    // Phase 0: no idling, long result hold-off over a frame past capacity
    hold_req = 1'b1;
    run_frames(ITEMS_PER_PHASE, 1'b1);
    drain_pairs();

    // Phase 1: sender idles
    gap_pct = 59;
    run_frames(ITEMS_PER_PHASE, 1'b0);
    drain_pairs();

    // Phase 2: receiver stalls, another overfull frame
    gap_pct   = 0;
    stall_pct = 59;
    run_frames(ITEMS_PER_PHASE, 1'b1);
    drain_pairs();

    // Phase 3: both sides idle
    gap_pct   = 23;
    stall_pct = 23;
    run_frames(ITEMS_PER_PHASE, 1'b0);
    drain_pairs();

    // Let any trailing scan finish before the verdict
    repeat (MAX_CIRCLES + 8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
